/* rtl/fqhwm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and control types for the queue with high-water mark.
// Depends on nothing; every other file of the block imports it.
package fqhwm_pkg;

  // Capacity of the queue in data words.
  localparam int DEPTH = 16;

  // Field widths of the channels.
  localparam int DATA_W  = 64;
  localparam int LEVEL_W = 5;
  localparam int COUNT_W = 32;
  localparam int CMD_W   = 1;

  // Pointers run over twice the capacity so that full and empty differ.
  localparam int PTR_SPAN = 2 * DEPTH;
  localparam int PTR_W    = $clog2(PTR_SPAN);
  localparam int ADDR_W   = $clog2(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the offered item
    logic exec;  // carry out the captured item and post its result
  } fqhwm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the result register can take a new result this cycle
  } fqhwm_sts_t;

endpackage

/* rtl/fqhwm_in_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel that carries one push or pop request per item.
// Depends on fqhwm_pkg for the field widths.
interface fqhwm_in_if
  import fqhwm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [DATA_W-1:0]   entry_data;

  modport source (output valid, output command, output entry_data, input ready);
  modport sink   (input valid, input command, input entry_data, output ready);
endinterface

/* rtl/fqhwm_out_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel that carries one result per item.
// Depends on fqhwm_pkg for the field widths.
interface fqhwm_out_if
  import fqhwm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [DATA_W-1:0]    read_data;
  logic [LEVEL_W-1:0]   fill_level;
  logic [LEVEL_W-1:0]   peak_fill;
  logic [COUNT_W-1:0]   rejected_pushes;

  modport source (output valid, output accepted, output read_data, output fill_level,
                  output peak_fill, output rejected_pushes, input ready);
  modport sink   (input valid, input accepted, input read_data, input fill_level,
                  input peak_fill, input rejected_pushes, output ready);
endinterface

/* rtl/fqhwm_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the queue: takes one item, then has it carried out once the
// result register is free. Depends on fqhwm_pkg for the command and status types.
module fqhwm_ctrl
  import fqhwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fqhwm_sts_t sts,
  output fqhwm_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= ST_EXEC;
            in_ready_r <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (sts.out_free) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;
  assign cmd.load = in_valid && in_ready_r;
  assign cmd.exec = (state_r == ST_EXEC) && sts.out_free;

  // The ready flag and the state must always agree.
  a_ready_matches_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r == (state_r == ST_IDLE))
    else $error("input ready disagrees with controller state");

  // An item that has been taken is carried out before the next one is taken.
  a_load_then_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load)
    else $error("second item taken before the first was carried out");

  // While the result register stays occupied, a taken item keeps the input closed.
  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready_r && !sts.out_free) |=> !in_ready_r)
    else $error("input reopened before the held item was carried out");

endmodule

/* rtl/fqhwm_dp.sv */
`timescale 1ns / 1ps
// Datapath of the queue: word store, pointers, peak mark, refusal counter and
// result register. Depends on fqhwm_pkg for widths, codes and control types.
module fqhwm_dp
  import fqhwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  fqhwm_cmd_t          cmd,
  output fqhwm_sts_t          sts,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [DATA_W-1:0]   in_entry_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [LEVEL_W-1:0]  out_fill_level,
  output logic [LEVEL_W-1:0]  out_peak_fill,
  output logic [COUNT_W-1:0]  out_rejected_pushes
);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = p + PTR_W'(1);
    if (p == PTR_W'(PTR_SPAN - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = p;
    if (p >= PTR_W'(DEPTH)) begin
      s = p - PTR_W'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  // Word store, written and read in clocked blocks.
  logic [DATA_W-1:0]  mem [DEPTH];

  logic [CMD_W-1:0]   cmd_r;
  logic [DATA_W-1:0]  data_r;
  logic [DATA_W-1:0]  rd_word_r;

  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   peak_r, peak_nxt;
  logic [COUNT_W-1:0] refusals_r, refusals_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accepted_r;
  logic [DATA_W-1:0]  read_data_r;
  logic [LEVEL_W-1:0] fill_level_r;

  logic [PTR_W:0]     level_wide;
  logic [PTR_W-1:0]   level;
  logic [PTR_W-1:0]   new_level;
  logic               full;
  logic               empty;
  logic               mem_we;
  logic               accepted_nxt;
  logic [DATA_W-1:0]  read_data_nxt;

  always_comb begin
    if (wr_ptr_r >= rd_ptr_r) begin
      level_wide = {1'b0, wr_ptr_r - rd_ptr_r};
    end else begin
      level_wide = {1'b0, wr_ptr_r} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, rd_ptr_r};
    end
    level = level_wide[PTR_W-1:0];
    full  = (level == PTR_W'(DEPTH));
    empty = (level == '0);
  end

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    peak_nxt      = peak_r;
    refusals_nxt  = refusals_r;
    new_level     = level;
    mem_we        = 1'b0;
    accepted_nxt  = 1'b0;
    read_data_nxt = '0;
    if (cmd.exec) begin
      if (cmd_r == CMD_PUSH) begin
        if (full) begin
          refusals_nxt = refusals_r + COUNT_W'(1);
        end else begin
          mem_we       = 1'b1;
          wr_ptr_nxt   = ptr_next(wr_ptr_r);
          new_level    = level + PTR_W'(1);
          accepted_nxt = 1'b1;
          if (new_level > peak_r) begin
            peak_nxt = new_level;
          end
        end
      end else begin
        if (!empty) begin
          read_data_nxt = rd_word_r;
          rd_ptr_nxt    = ptr_next(rd_ptr_r);
          new_level     = level - PTR_W'(1);
          accepted_nxt  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      peak_r      <= '0;
      refusals_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      peak_r      <= peak_nxt;
      refusals_r  <= refusals_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item capture and result payload need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      data_r <= in_entry_data;
    end
    if (cmd.exec) begin
      accepted_r   <= accepted_nxt;
      read_data_r  <= read_data_nxt;
      fill_level_r <= LEVEL_W'(new_level);
    end
  end

  // The head word is read every cycle; writes only happen while an item is
  // carried out, so the registered copy is current when a pop needs it.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_slot(wr_ptr_r)] <= data_r;
    end
    rd_word_r <= mem[ptr_slot(rd_ptr_r)];
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = accepted_r;
  assign out_read_data       = read_data_r;
  assign out_fill_level      = fill_level_r;
  assign out_peak_fill       = LEVEL_W'(peak_r);
  assign out_rejected_pushes = refusals_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r < PTR_W'(PTR_SPAN - 1) || wr_ptr_r == PTR_W'(PTR_SPAN - 1)) &&
    (rd_ptr_r < PTR_W'(PTR_SPAN - 1) || rd_ptr_r == PTR_W'(PTR_SPAN - 1)))
    else $error("queue pointer left its range");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= PTR_W'(DEPTH) && peak_r <= PTR_W'(DEPTH))
    else $error("fill level or peak mark beyond capacity");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> peak_r >= $past(peak_r))
    else $error("peak mark went down");

endmodule

/* rtl/fifo_queue_with_high_water_mark.sv */
`timescale 1ns / 1ps
// An item is captured while the controller is idle and carried out in the execute
// state once the result register is free, which registers its result; a waiting
// result delays the next one until it is taken. A new item is not taken before the
// last one is carried out with the head word read from the registered store port.
// Reset: rst_n is synchronous and active low; the queue comes up empty with the
// peak mark and refusal count at zero. Stored words are not cleared.
module fifo_queue_with_high_water_mark
  import fqhwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fqhwm_in_if.sink    in_chan,
  fqhwm_out_if.source out_chan
);

  // The controller and the datapath talk only through these two structs.
  fqhwm_cmd_t cmd;
  fqhwm_sts_t sts;

  // The controller takes an item while it is idle. The item is then carried
  // out as soon as the result register is free, so a new item can be taken
  // while an earlier result still waits at the output.
  fqhwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the word store, both pointers, the peak mark, the
  // refusal counter and the result register that drives the output channel.
  fqhwm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_chan.command),
    .in_entry_data       (in_chan.entry_data),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_accepted        (out_chan.accepted),
    .out_read_data       (out_chan.read_data),
    .out_fill_level      (out_chan.fill_level),
    .out_peak_fill       (out_chan.peak_fill),
    .out_rejected_pushes (out_chan.rejected_pushes)
  );

endmodule
